// ----- rtl/i2cm_pkg.sv -----
// Package for the I2C master byte engine: item, result and configuration types,
// command codes and constants. It depends on nothing else.
package i2cm_pkg;

	// Raw input item as it arrives on the push side.
	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic       ack_after_read;
		logic       sda_in;
	} item_t;

	// Result item as it leaves on the pop side.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} result_t;

	// Action codes of the input item.
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_READ  = 3'd3;
	localparam logic [2:0] ACT_STOP  = 3'd4;

	// Decoded command carried from the front part to the back part.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_WRITE,
		CMD_READ,
		CMD_STOP
	} cmd_t;

	// Classified item held in the queue between front and back.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
		logic       ack_after_read;
		logic       sda_in;
	} op_t;

	// Configuration registers as seen by the bit engine.
	typedef struct packed {
		logic [15:0] delay_ticks;
		logic [7:0]  ack_wait_limit;
	} cfg_t;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
	localparam logic [1:0] ST_START_ERR = 2'd2;
	localparam logic [1:0] ST_NO_ACK    = 2'd3;

	// Register indexes (taken from paddr[2]).
	localparam logic REG_DELAY    = 1'b0;
	localparam logic REG_ACK_WAIT = 1'b1;

	localparam logic [15:0] DELAY_RESET    = 16'd1;
	localparam logic [7:0]  ACK_WAIT_RESET = 8'd10;

	// Bits in one byte on the bus.
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Depth of the queues and width of their pointers.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

// ----- rtl/i2c_master_byte_engine.sv -----
// I2C master byte engine: one result item for every timing-tick item.
// A pushed item is registered in the front queue, and the sequencer step that it
// drives is then written into the result queue; each side has a two-entry queue.
// Throughput: one item per cycle while the result queue has room or is popped.
// Reset (arst_n low) empties both queues, releases SCL and SDA, sets the engine
// idle and restores delay_ticks to 1 and ack_wait_limit to 10.
module i2c_master_byte_engine import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	logic op_valid;
	logic deq;
	op_t  op;
	logic wr_en;

	// Configuration registers; the low address bits select nothing.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks    <= DELAY_RESET;
			cfg_q.ack_wait_limit <= ACK_WAIT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DELAY:    cfg_q.delay_ticks    <= pwdata[15:0];
				REG_ACK_WAIT: cfg_q.ack_wait_limit <= pwdata[7:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DELAY:    prdata = {16'd0, cfg_q.delay_ticks};
			REG_ACK_WAIT: prdata = {24'd0, cfg_q.ack_wait_limit};
			default:      prdata = '0;
		endcase
	end

	i2cm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.deq      (deq),
		.op_valid (op_valid),
		.op       (op)
	);

	i2cm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.op_valid (op_valid),
		.op       (op),
		.deq      (deq),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ----- rtl/i2cm_front.sv -----
// Front part of the I2C master byte engine: accepts input items, decodes the
// action code and holds the classified items in a short queue. Uses i2cm_pkg.
module i2cm_front import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	input  logic    deq,
	output logic    op_valid,
	output op_t     op
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	op_t               op_new;
	logic              do_push;
	logic              do_pop;

	// Classify the action; unknown codes behave as a plain tick.
	always_comb begin
		op_new.data_byte      = item.data_byte;
		op_new.ack_after_read = item.ack_after_read;
		op_new.sda_in         = item.sda_in;
		unique case (item.action)
			ACT_START: op_new.cmd = CMD_START;
			ACT_WRITE: op_new.cmd = CMD_WRITE;
			ACT_READ:  op_new.cmd = CMD_READ;
			ACT_STOP:  op_new.cmd = CMD_STOP;
			default:   op_new.cmd = CMD_NONE;
		endcase
	end

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = deq && op_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= op_new;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

endmodule

// ----- rtl/i2cm_back.sv -----
// Back part of the I2C master byte engine: the SCL/SDA phase sequencer that
// runs one tick per item, and the result queue. Uses i2cm_pkg.
module i2cm_back import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    op_valid,
	input  op_t     op,
	output logic    deq,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_S0, PH_S1, PH_P0, PH_P1, PH_P2,
		PH_W0, PH_W1, PH_W2, PH_W3, PH_W4, PH_W5, PH_W6,
		PH_R0, PH_R1, PH_R2, PH_R3, PH_R4, PH_R5
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [3:0]  bit_q, bit_d, bit_inc;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] dly_q, dly_d, dly_dec, dly_load;
	logic [7:0]  awc_q, awc_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ackl_q, ackl_d;
	logic        nak_q, nak_d;
	logic [1:0]  st_q, st_d;
	logic [7:0]  rd_q, rd_d;
	logic        done_d;
	result_t     res_d;

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign dly_load = (cfg.delay_ticks == '0) ? 16'd1 : cfg.delay_ticks;
	assign dly_dec  = (dly_q != '0) ? dly_q - 16'd1 : dly_q;
	assign bit_inc  = bit_q + 4'd1;

	// One tick of the sequencer: start a command when idle, else count down
	// the bus delay and take the next phase step when it runs out.
	always_comb begin
		ph_d    = ph_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		dly_d   = dly_q;
		awc_d   = awc_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ackl_d  = ackl_q;
		nak_d   = nak_q;
		st_d    = st_q;
		rd_d    = rd_q;
		done_d  = 1'b0;
		if (ph_q == PH_IDLE) begin
			if (op.cmd != CMD_NONE) begin
				bit_d = '0;
				awc_d = '0;
				nak_d = 1'b0;
				dly_d = dly_load;
				unique case (op.cmd)
					CMD_START: begin
						scl_d = 1'b1;
						sda_d = 1'b1;
						ph_d  = PH_S0;
					end
					CMD_WRITE: begin
						shift_d = op.data_byte;
						scl_d   = 1'b0;
						ph_d    = PH_W0;
					end
					CMD_READ: begin
						ackl_d  = op.ack_after_read;
						shift_d = '0;
						scl_d   = 1'b0;
						sda_d   = 1'b1;
						ph_d    = PH_R0;
					end
					CMD_STOP: begin
						scl_d = 1'b0;
						sda_d = 1'b0;
						ph_d  = PH_P0;
					end
					default: ph_d = PH_IDLE;
				endcase
			end
		end else begin
			dly_d = dly_dec;
			if (dly_dec == '0) begin
				dly_d = dly_load;
				unique case (ph_q)
					// Start condition: bus must be free, then SDA must follow.
					PH_S0: begin
						if (!op.sda_in) begin
							ph_d = PH_IDLE; st_d = ST_BUS_BUSY; done_d = 1'b1;
						end else begin
							sda_d = 1'b0; ph_d = PH_S1;
						end
					end
					PH_S1: begin
						if (op.sda_in) begin
							ph_d = PH_IDLE; st_d = ST_START_ERR; done_d = 1'b1;
						end else begin
							scl_d = 1'b0; ph_d = PH_IDLE; st_d = ST_OK; done_d = 1'b1;
						end
					end
					// Stop condition.
					PH_P0: begin
						scl_d = 1'b1; ph_d = PH_P1;
					end
					PH_P1: begin
						sda_d = 1'b1; ph_d = PH_P2;
					end
					PH_P2: begin
						ph_d   = PH_IDLE;
						st_d   = nak_q ? ST_NO_ACK : ST_OK;
						done_d = 1'b1;
						nak_d  = 1'b0;
					end
					// Byte write, MSB first.
					PH_W0: begin
						sda_d   = shift_q[7];
						shift_d = {shift_q[6:0], 1'b0};
						ph_d    = PH_W1;
					end
					PH_W1: begin
						scl_d = 1'b1; ph_d = PH_W2;
					end
					PH_W2: begin
						scl_d = 1'b0; ph_d = PH_W3;
					end
					PH_W3: begin
						bit_d = bit_inc;
						if (bit_inc < BITS_PER_BYTE) begin
							sda_d   = shift_q[7];
							shift_d = {shift_q[6:0], 1'b0};
							ph_d    = PH_W1;
						end else begin
							sda_d = 1'b1; ph_d = PH_W4;
						end
					end
					PH_W4: begin
						scl_d = 1'b1; ph_d = PH_W5;
					end
					// Acknowledge wait; a timeout falls into a stop sequence.
					PH_W5, PH_W6: begin
						if (!op.sda_in) begin
							scl_d = 1'b0; ph_d = PH_IDLE; st_d = ST_OK; done_d = 1'b1;
						end else if (ph_q == PH_W6) begin
							nak_d = 1'b1;
							scl_d = 1'b0;
							sda_d = 1'b0;
							ph_d  = PH_P0;
						end else if (awc_q >= cfg.ack_wait_limit) begin
							ph_d = PH_W6;
						end else begin
							awc_d = awc_q + 8'd1;
							ph_d  = PH_W5;
						end
					end
					// Byte read, sampled as SCL rises.
					PH_R0: begin
						scl_d   = 1'b1;
						shift_d = {shift_q[6:0], op.sda_in};
						ph_d    = PH_R1;
					end
					PH_R1: begin
						bit_d = bit_inc;
						scl_d = 1'b0;
						ph_d  = (bit_inc < BITS_PER_BYTE) ? PH_R0 : PH_R2;
					end
					PH_R2: begin
						rd_d = shift_q;
						if (ackl_q) begin
							sda_d = 1'b0; ph_d = PH_R3;
						end else begin
							ph_d = PH_R4;
						end
					end
					PH_R4: begin
						sda_d = 1'b1; ph_d = PH_R3;
					end
					PH_R3: begin
						scl_d = 1'b1; ph_d = PH_R5;
					end
					PH_R5: begin
						scl_d = 1'b0; ph_d = PH_IDLE; st_d = ST_OK; done_d = 1'b1;
					end
					default: ph_d = PH_IDLE;
				endcase
			end
		end
	end

	// Result of this tick.
	always_comb begin
		res_d.scl_level = scl_d;
		res_d.sda_level = sda_d;
		res_d.busy_res  = (ph_d != PH_IDLE);
		res_d.done_res  = done_d;
		res_d.status    = st_d;
		res_d.read_data = rd_d;
	end

	// An item is taken when the result queue has room, or frees one now.
	assign do_pop = pop && !empty;
	assign deq    = op_valid && ((cnt_q != QCNT_W'(QDEPTH)) || do_pop);
	assign empty  = (cnt_q == '0);
	assign result = mem_q[rd_ptr_q];

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			dly_q   <= '0;
			awc_q   <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ackl_q  <= 1'b0;
			nak_q   <= 1'b0;
			st_q    <= ST_OK;
			rd_q    <= '0;
		end else if (deq) begin
			ph_q    <= ph_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			dly_q   <= dly_d;
			awc_q   <= awc_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ackl_q  <= ackl_d;
			nak_q   <= nak_d;
			st_q    <= st_d;
			rd_q    <= rd_d;
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (deq) begin
			mem_q[wr_ptr_q] <= res_d;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (deq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(deq) - QCNT_W'(do_pop);
		end
	end

endmodule

// ----- rtl/i2cm_checker.sv -----
// Port-level checker for the I2C master byte engine, bound to the top level.
// Uses i2cm_pkg for the result type.
module i2cm_checker import i2cm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input result_t     result,
	input logic        pready
);

	// A result that finishes a command never reports the engine as busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.done_res) |-> !result.busy_res)
		else $error("done result still reports busy");

	// A start failure leaves the lines as they are, so a finished bus-busy report
	// always shows both SCL and SDA released.
	a_busy_status_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.done_res && result.status == ST_BUS_BUSY) |->
		(result.scl_level && result.sda_level))
		else $error("bus busy report with lines not released");

	// A result waiting for pop holds still.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	// Writes on the configuration port never stall.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result),
	.pready (pready)
);

// ----- bench/i2c_master_byte_engine_tb.sv -----
// Self-checking testbench for the I2C master byte engine: random and directed
// timing-tick items, a tick-exact behavioral predictor and a result scoreboard.
// Depends on i2cm_pkg and the i2c_master_byte_engine RTL.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;
	import i2cm_pkg::*;

	// Action codes that the package leaves unnamed.
	localparam logic [2:0] ACT_IDLE         = 3'd0;
	localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

	// Cycles with no accepted item and no popped result after which the run is declared hung.
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 200;
	localparam int PRINT_CAP   = 200;

	// Bus sequencer phases of the predictor.
	typedef enum logic [4:0] {
		P_IDLE, P_START_REL, P_START_LOW, P_STOP_A, P_STOP_B, P_STOP_C,
		P_WR_BIT, P_WR_RISE, P_WR_FALL, P_WR_NEXT, P_ACK_RISE, P_ACK_POLL, P_ACK_LAST,
		P_RD_RISE, P_RD_FALL, P_RD_ANSWER, P_RD_CLOCK, P_RD_NACK, P_RD_END
	} bus_phase_e;

	// How the simulated slave and bus answer on SDA during a command.
	typedef enum logic [1:0] {LINE_RAND, LINE_GOOD, LINE_HIGH, LINE_LOW} line_mode_e;

	typedef struct packed {
		bus_phase_e  phase;
		logic [3:0]  bit_cnt;
		logic [7:0]  shreg;
		logic [15:0] wait_cnt;
		logic [7:0]  poll_cnt;
		logic        scl;
		logic        sda;
		logic        ack_latch;
		logic        nak_pend;
		logic        done;
		logic [1:0]  status;
		logic [7:0]  rdata;
		logic [15:0] delay_ticks;
		logic [7:0]  ack_limit;
	} engine_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	item_t       item = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	item_t   stim_q[$];
	result_t expected_q[$];
	engine_t chk_st;
	engine_t gen_st;
	result_t predicted;
	result_t oldest;
	int      gen_count = 0;
	int      results_seen = 0;
	int      errors = 0;
	int      idle_run = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      took_item = 1'b0;
	bit      took_result = 1'b0;
	bit      recv_hold = 1'b0;
	bit      long_hold_req = 1'b0;

	i2c_master_byte_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial forever #5 clk = ~clk;

	// Engine state right after reset.
	function automatic engine_t fresh_engine();
		engine_t s;
		s = '0;
		s.phase = P_IDLE;
		s.scl = 1'b1;
		s.sda = 1'b1;
		s.delay_ticks = DELAY_RESET;
		s.ack_limit = ACK_WAIT_RESET;
		return s;
	endfunction

	// Move to a phase and load one bus delay; a zero delay counts as one tick.
	function automatic engine_t enter(engine_t s, bus_phase_e p);
		s.phase = p;
		s.wait_cnt = (s.delay_ticks == 16'd0) ? 16'd1 : s.delay_ticks;
		return s;
	endfunction

	function automatic engine_t finish_cmd(engine_t s, logic [1:0] st);
		s.phase = P_IDLE;
		s.status = st;
		s.done = 1'b1;
		return s;
	endfunction

	// Put the next data bit on SDA, MSB first.
	function automatic engine_t shift_out(engine_t s);
		s.sda = s.shreg[7];
		s.shreg = {s.shreg[6:0], 1'b0};
		return enter(s, P_WR_RISE);
	endfunction

	// One timing tick of the engine: advances the state and forms the result item.
	task automatic engine_tick(inout engine_t s, input item_t it, output result_t r);
		s.done = 1'b0;
		if (s.phase == P_IDLE) begin
			if (it.action == ACT_START || it.action == ACT_WRITE ||
			    it.action == ACT_READ || it.action == ACT_STOP) begin
				s.bit_cnt = '0;
				s.poll_cnt = '0;
				s.nak_pend = 1'b0;
				case (it.action)
					ACT_START: begin
						s.scl = 1'b1;
						s.sda = 1'b1;
						s = enter(s, P_START_REL);
					end
					ACT_WRITE: begin
						s.shreg = it.data_byte;
						s.scl = 1'b0;
						s = enter(s, P_WR_BIT);
					end
					ACT_READ: begin
						s.ack_latch = it.ack_after_read;
						s.shreg = '0;
						s.scl = 1'b0;
						s.sda = 1'b1;
						s = enter(s, P_RD_RISE);
					end
					default: begin
						s.scl = 1'b0;
						s.sda = 1'b0;
						s = enter(s, P_STOP_A);
					end
				endcase
			end
		end else begin
			if (s.wait_cnt != 16'd0)
				s.wait_cnt = s.wait_cnt - 16'd1;
			if (s.wait_cnt == 16'd0) begin
				case (s.phase)
					P_START_REL: begin
						if (!it.sda_in)
							s = finish_cmd(s, ST_BUS_BUSY);
						else begin
							s.sda = 1'b0;
							s = enter(s, P_START_LOW);
						end
					end
					P_START_LOW: begin
						if (it.sda_in)
							s = finish_cmd(s, ST_START_ERR);
						else begin
							s.scl = 1'b0;
							s = finish_cmd(s, ST_OK);
						end
					end
					P_STOP_A: begin
						s.scl = 1'b1;
						s = enter(s, P_STOP_B);
					end
					P_STOP_B: begin
						s.sda = 1'b1;
						s = enter(s, P_STOP_C);
					end
					P_STOP_C: begin
						s = finish_cmd(s, s.nak_pend ? ST_NO_ACK : ST_OK);
						s.nak_pend = 1'b0;
					end
					P_WR_BIT: s = shift_out(s);
					P_WR_RISE: begin
						s.scl = 1'b1;
						s = enter(s, P_WR_FALL);
					end
					P_WR_FALL: begin
						s.scl = 1'b0;
						s = enter(s, P_WR_NEXT);
					end
					P_WR_NEXT: begin
						s.bit_cnt = s.bit_cnt + 4'd1;
						if (s.bit_cnt < BITS_PER_BYTE)
							s = shift_out(s);
						else begin
							s.sda = 1'b1;
							s = enter(s, P_ACK_RISE);
						end
					end
					P_ACK_RISE: begin
						s.scl = 1'b1;
						s = enter(s, P_ACK_POLL);
					end
					P_ACK_POLL, P_ACK_LAST: begin
						if (!it.sda_in) begin
							s.scl = 1'b0;
							s = finish_cmd(s, ST_OK);
						end else if (s.phase == P_ACK_LAST) begin
							// Acknowledge never came: release the bus with a stop.
							s.nak_pend = 1'b1;
							s.scl = 1'b0;
							s.sda = 1'b0;
							s = enter(s, P_STOP_A);
						end else if (s.poll_cnt >= s.ack_limit)
							s = enter(s, P_ACK_LAST);
						else begin
							s.poll_cnt = s.poll_cnt + 8'd1;
							s = enter(s, P_ACK_POLL);
						end
					end
					P_RD_RISE: begin
						s.scl = 1'b1;
						s.shreg = {s.shreg[6:0], it.sda_in};
						s = enter(s, P_RD_FALL);
					end
					P_RD_FALL: begin
						s.bit_cnt = s.bit_cnt + 4'd1;
						s.scl = 1'b0;
						if (s.bit_cnt < BITS_PER_BYTE)
							s = enter(s, P_RD_RISE);
						else
							s = enter(s, P_RD_ANSWER);
					end
					P_RD_ANSWER: begin
						s.rdata = s.shreg;
						if (s.ack_latch) begin
							s.sda = 1'b0;
							s = enter(s, P_RD_CLOCK);
						end else
							s = enter(s, P_RD_NACK);
					end
					P_RD_NACK: begin
						s.sda = 1'b1;
						s = enter(s, P_RD_CLOCK);
					end
					P_RD_CLOCK: begin
						s.scl = 1'b1;
						s = enter(s, P_RD_END);
					end
					P_RD_END: begin
						s.scl = 1'b0;
						s = finish_cmd(s, ST_OK);
					end
					default: s.phase = P_IDLE;
				endcase
			end
		end
		r.scl_level = s.scl;
		r.sda_level = s.sda;
		r.busy_res = (s.phase != P_IDLE);
		r.done_res = s.done;
		r.status = s.status;
		r.read_data = s.rdata;
	endtask

	task automatic report(input string msg);
		if (errors < PRINT_CAP)
			$display("MISMATCH: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got, want));
	endtask

	// SDA level that the bus shows on one tick, chosen from the engine's phase.
	function automatic logic line_level(bus_phase_e ph, line_mode_e m);
		logic good;
		good = (m == LINE_GOOD);
		if (m == LINE_HIGH)
			return 1'b1;
		if (m == LINE_LOW)
			return 1'b0;
		case (ph)
			P_START_REL: return good || ($urandom_range(9) != 0);
			P_START_LOW: return !good && ($urandom_range(9) == 0);
			P_ACK_POLL, P_ACK_LAST: return !good && ($urandom_range(3) != 0);
			default: return $urandom_range(1) != 0;
		endcase
	endfunction

	function automatic line_mode_e pick_mode();
		int r;
		r = $urandom_range(9);
		if (r < 7)
			return LINE_RAND;
		if (r == 7)
			return LINE_GOOD;
		if (r == 8)
			return LINE_HIGH;
		return LINE_LOW;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.action = 3'($urandom_range(ACT_UNUSED_LAST));
		it.data_byte = 8'($urandom_range(255));
		it.ack_after_read = 1'($urandom_range(1));
		it.sda_in = 1'($urandom_range(1));
		return it;
	endfunction

	// Queue one item and keep the generation-side engine in step with it.
	task automatic add_item(input item_t it);
		result_t ignored;
		engine_tick(gen_st, it, ignored);
		stim_q.push_back(it);
		gen_count++;
	endtask

	// Tick until the engine is idle again, optionally throwing commands at it.
	task automatic drain_gen(input line_mode_e m, input bit noise);
		item_t it;
		while (gen_st.phase != P_IDLE) begin
			it = rand_item();
			if (!(noise && $urandom_range(7) == 0))
				it.action = ACT_IDLE;
			it.sda_in = line_level(gen_st.phase, m);
			add_item(it);
		end
	endtask

	task automatic gen_command(input logic [2:0] act, input logic [7:0] data, input logic ackr,
			input line_mode_e m, input bit noise);
		item_t it;
		it = rand_item();
		it.action = act;
		it.data_byte = data;
		it.ack_after_read = ackr;
		add_item(it);
		drain_gen(m, noise);
	endtask

	// Mostly whole transactions with random content, plus noise and idle ticks.
	task automatic run_random(input int n);
		int stop_at;
		int r;
		item_t it;
		stop_at = gen_count + n;
		while (gen_count < stop_at) begin
			r = $urandom_range(99);
			if (r < 15) begin
				add_item(rand_item());
				drain_gen(LINE_RAND, 1'b1);
			end else if (r < 25) begin
				repeat ($urandom_range(1, 4)) begin
					it = rand_item();
					if ($urandom_range(1))
						it.action = ACT_IDLE;
					else
						it.action = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
					add_item(it);
				end
			end else begin
				gen_command(ACT_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
					pick_mode(), $urandom_range(3) == 0);
				repeat ($urandom_range(1, 3))
					gen_command($urandom_range(1) ? ACT_WRITE : ACT_READ,
						8'($urandom_range(255)), 1'($urandom_range(1)), pick_mode(),
						$urandom_range(3) == 0);
				gen_command(ACT_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
					pick_mode(), $urandom_range(3) == 0);
			end
		end
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic bus_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Write both registers, mirror them into the predictors and read them back.
	task automatic set_config(input logic [15:0] d, input logic [7:0] lim);
		logic [31:0] rd;
		bus_access(1'b1, {REG_DELAY, 2'b00}, {16'd0, d}, rd);
		bus_access(1'b1, {REG_ACK_WAIT, 2'b00}, {24'd0, lim}, rd);
		chk_st.delay_ticks = d;
		chk_st.ack_limit = lim;
		gen_st.delay_ticks = d;
		gen_st.ack_limit = lim;
		bus_access(1'b0, {REG_DELAY, 2'b00}, '0, rd);
		if (rd[15:0] != d)
			report($sformatf("delay_ticks read back %0d, expected %0d", rd[15:0], d));
		bus_access(1'b0, {REG_ACK_WAIT, 2'b00}, '0, rd);
		if (rd[7:0] != lim)
			report($sformatf("ack_wait_limit read back %0d, expected %0d", rd[7:0], lim));
	endtask

	// Wait until every queued item went in and every result came out.
	task automatic wait_results_done();
		while (stim_q.size() != 0 || expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] d, input logic [7:0] lim, input int sp,
			input int rp, input int n);
		wait_results_done();
		set_config(d, lim);
		@(posedge clk);
		send_idle_pct = sp;
		recv_idle_pct = rp;
		run_random(n);
	endtask

	// Input driver: offers the oldest pending item and holds it until accepted.
	always @(negedge clk) begin
		if (!arst_n)
			push <= 1'b0;
		else if (!push || took_item) begin
			if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				item <= stim_q[0];
			end else
				push <= 1'b0;
		end
	end

	// Result side: random stalls, plus one long hold-off.
	always @(negedge clk)
		pop <= arst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);

	initial begin
		wait (long_hold_req);
		@(posedge clk);
		recv_hold = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		recv_hold = 1'b0;
	end

	// Monitor: checks popped results, predicts accepted items, and runs the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			took_result = pop && !empty;
			if (took_result) begin
				if (expected_q.size() == 0)
					report($sformatf("result %0d arrived with none expected", results_seen));
				else begin
					oldest = expected_q.pop_front();
					check_field("scl_level", result.scl_level, oldest.scl_level);
					check_field("sda_level", result.sda_level, oldest.sda_level);
					check_field("busy_res", result.busy_res, oldest.busy_res);
					check_field("done_res", result.done_res, oldest.done_res);
					check_field("status", result.status, oldest.status);
					check_field("read_data", result.read_data, oldest.read_data);
				end
				results_seen++;
			end
			took_item = push && !full;
			if (took_item) begin
				engine_tick(chk_st, item, predicted);
				expected_q.push_back(predicted);
				stim_q.delete(0);
			end
			if (took_item || took_result)
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		chk_st = fresh_engine();
		gen_st = fresh_engine();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed part at the reset configuration.
		add_item('0);
		add_item('1);
		gen_command(ACT_START, 8'h00, 1'b0, LINE_GOOD, 1'b0);
		gen_command(ACT_WRITE, 8'h00, 1'b0, LINE_GOOD, 1'b0);
		// All ones with no acknowledge: times out, stops and flags it.
		gen_command(ACT_WRITE, 8'hFF, 1'b1, LINE_HIGH, 1'b0);
		// Bus held low before the start, then SDA stuck high through it.
		gen_command(ACT_START, 8'h00, 1'b0, LINE_LOW, 1'b0);
		gen_command(ACT_START, 8'h00, 1'b0, LINE_HIGH, 1'b0);
		gen_command(ACT_READ, 8'h00, 1'b1, LINE_HIGH, 1'b0);
		gen_command(ACT_READ, 8'hFF, 1'b0, LINE_LOW, 1'b0);
		// Commands that arrive while the engine is busy must be ignored.
		gen_command(ACT_WRITE, 8'hA5, 1'b0, LINE_GOOD, 1'b1);
		gen_command(ACT_STOP, 8'h00, 1'b0, LINE_GOOD, 1'b0);
		add_item({ACT_UNUSED_FIRST, 8'h5A, 1'b0, 1'b1});
		add_item({ACT_UNUSED_LAST, 8'h00, 1'b1, 1'b0});

		// Random phases over several settings and idling patterns.
		run_phase(16'd0, 8'd0, 75, 0, 130);
		run_phase(16'd2, 8'd40, 0, 75, 130);
		long_hold_req = 1'b1;
		run_phase(16'd1, 8'd3, 38, 38, 130);
		run_phase(16'd3, 8'd1, 0, 0, 65);
		// Sender pauses until the engine has answered everything.
		wait_results_done();
		run_random(65);
		// Long delay: one start that finds the bus busy after a full period.
		run_phase(16'd64, 8'd10, 0, 0, 0);
		gen_command(ACT_START, 8'h00, 1'b0, LINE_LOW, 1'b0);
		run_phase(DELAY_RESET, ACK_WAIT_RESET, 75, 0, 130);

		wait_results_done();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
